[src/skts_pkg.sv]
// Shared types and constants for the scalar Kalman temperature smoother.
// No dependencies; imported by every module of the block.
package skts_pkg;

  // Field and register widths fixed by the interface.
  localparam int NOISE_W     = 24;
  localparam int TEMP_W      = 15;
  localparam int MIN_OUT_W   = 14;
  localparam int DUTY_W      = 14;
  localparam int MIN_STATE_W = 16;
  localparam int EST_W       = 32;
  localparam int EST_FRAC    = 16;
  localparam int INDEX_W     = 1;

  localparam int FRACTION_BITS_DEFAULT = 24;

  // Reset values.
  localparam logic [NOISE_W-1:0]     PROCESS_NOISE_RESET = NOISE_W'(8389);
  localparam logic [NOISE_W-1:0]     MEASURE_NOISE_RESET = NOISE_W'(503316);
  localparam logic [EST_W-1:0]       ESTIMATE_RESET      = EST_W'(25) << EST_FRAC;
  localparam logic [MIN_STATE_W-1:0] MINIMUM_RESET       = MIN_STATE_W'(5000);

  // Output saturation limits.
  localparam logic [MIN_OUT_W-1:0] MIN_OUT_LOW  = 14'h2000;
  localparam logic [MIN_OUT_W-1:0] MIN_OUT_HIGH = 14'h1FFF;
  localparam logic [DUTY_W-1:0]    DUTY_MAX     = 14'h3FFF;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [INDEX_W-1:0] REG_MEASURE_NOISE = 1'b1;

  // Control of a bit-serial unit: load operands, then advance one bit.
  typedef struct packed {
    logic load;
    logic step;
  } skts_ctl_t;

endpackage

[src/skts_divider.sv]
// Bit-serial restoring divider producing the Kalman gain, one quotient bit a cycle while step is held.
// Depends on skts_pkg for the control struct.
module skts_divider import skts_pkg::*; #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 27,
  parameter int QUO_W = 25
) (
  input  logic             clk,
  input  skts_ctl_t        ctl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quotient
);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo;
  logic [DEN_W:0]   den_ext;
  logic             ge;
  logic [DEN_W:0]   rem_sel;

  assign den_ext = {1'b0, den_r};
  assign ge      = (rem >= den_ext);
  assign rem_sel = ge ? (rem - den_ext) : rem;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem   <= (DEN_W+1)'(num);
      den_r <= den;
      quo   <= '0;
    end else if (ctl.step) begin
      quo <= {quo[QUO_W-2:0], ge};
      rem <= {rem_sel[DEN_W-1:0], 1'b0};
    end
  end

  // Force a zero gain on a zero denominator.
  assign quotient = (den_r == '0) ? '0 : quo;

endmodule

[src/skts_serial_mult.sv]
// Bit-serial shift-add multiplier returning the product shifted right by B_W-1.
// Depends on skts_pkg for the control struct.
module skts_serial_mult import skts_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 25
) (
  input  logic           clk,
  input  skts_ctl_t      ctl,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [A_W:0]   product
);

  logic [A_W-1:0] a_r;
  logic [B_W-1:0] b_r;
  logic [A_W-1:0] hi;
  logic           last_bit;
  logic [A_W:0]   sum;

  assign sum = {1'b0, hi} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r      <= a;
      b_r      <= b;
      hi       <= '0;
      last_bit <= 1'b0;
    end else if (ctl.step) begin
      // Drop one product bit each step; the last one dropped is bit B_W-1.
      hi       <= sum[A_W:1];
      last_bit <= sum[0];
      b_r      <= b_r >> 1;
    end
  end

  assign product = {hi, last_bit};

endmodule

[src/scalar_kalman_temperature_smoother.sv]
// Top level of the scalar Kalman temperature smoother: sequencer, state and output register.
// Depends on skts_pkg, skts_divider and skts_serial_mult.
//
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  sample_temp
// result    out        result_valid / result_ready  filtered_temp, minimum_temp, led_duty
// config    in         wr_en (no wait)              wr_index, wr_data
//
// Each sample passes in turn through PREP, DLOAD, DIV (the serial divider), MLOAD,
// MUL (both serial multiplies together), UPD, FILT and OUT before its result beat.
// A new sample is taken only once the previous result is loaded, so one sample
// is in flight at a time.
// Synchronous reset restores the noise registers, estimate, variance and minimum.
// A stalled result beat holds in the output register while the next sample is
// taken; the sequencer waits only if a second result is ready before the first leaves.
module scalar_kalman_temperature_smoother import skts_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [INDEX_W-1:0]          wr_index,
  input  logic [NOISE_W-1:0]          wr_data,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic signed [TEMP_W-1:0]    sample_temp,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [TEMP_W-1:0]    filtered_temp,
  output logic signed [MIN_OUT_W-1:0] minimum_temp,
  output logic [DUTY_W-1:0]           led_duty
);

  // Variance stays below max(1.0, 2^24) plus one process-noise step.
  localparam int VAR_W = ((FRACTION_BITS > NOISE_W) ? FRACTION_BITS : NOISE_W) + 2;
  localparam int DEN_W = VAR_W + 1;
  localparam int QUO_W = FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(QUO_W);
  localparam int INN_W = EST_W + 1;
  localparam logic [VAR_W-1:0] VARIANCE_RESET = VAR_W'(1) << FRACTION_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DLOAD = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MLOAD = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_FILT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]             state;
  logic [CNT_W-1:0]       cnt;

  // Configuration and filter state.
  logic [NOISE_W-1:0]     process_noise;
  logic [NOISE_W-1:0]     measure_noise;
  logic [EST_W-1:0]       estimate;
  logic [VAR_W-1:0]       variance;
  logic [MIN_STATE_W-1:0] running_minimum;

  // Per-sample working registers.
  logic [TEMP_W-1:0]      sample_r;
  logic                   innov_neg;
  logic [EST_W-1:0]       innov_mag;
  logic [TEMP_W-1:0]      filtered;

  skts_ctl_t              div_ctl;
  skts_ctl_t              mul_ctl;
  logic [QUO_W-1:0]       gain;
  logic [EST_W:0]         est_prod;
  logic [VAR_W:0]         var_prod;

  // Innovation: sample scaled to 16 fraction bits minus the estimate.
  logic [INN_W-1:0]       sample_wide;
  logic [INN_W-1:0]       innov;
  logic [INN_W-1:0]       innov_abs;
  logic [DEN_W-1:0]       den;

  assign sample_wide = {{(INN_W-TEMP_W-EST_FRAC){sample_r[TEMP_W-1]}}, sample_r,
                        {EST_FRAC{1'b0}}};
  assign innov       = sample_wide - {estimate[EST_W-1], estimate};
  assign innov_abs   = innov[INN_W-1] ? (-innov) : innov;
  assign den         = {1'b0, variance} + {{(DEN_W-NOISE_W){1'b0}}, measure_noise};

  // Truncate the estimate toward zero.
  logic [EST_W-1:0]       est_abs;
  logic [MIN_STATE_W-1:0] est_whole;
  logic [MIN_STATE_W-1:0] est_whole_neg;

  assign est_abs       = estimate[EST_W-1] ? (-estimate) : estimate;
  assign est_whole     = est_abs[EST_W-1:EST_FRAC];
  assign est_whole_neg = -est_whole;

  // Running minimum, duty and output saturation.
  logic [MIN_STATE_W-1:0] filt_ext;
  logic [MIN_STATE_W-1:0] min_next;
  logic [MIN_STATE_W:0]   duty_wide;
  logic [MIN_OUT_W-1:0]   min_sat;
  logic [DUTY_W-1:0]      duty_sat;
  logic                   out_free;

  assign filt_ext  = {filtered[TEMP_W-1], filtered};
  assign min_next  = ($signed(filt_ext) < $signed(running_minimum)) ? filt_ext
                                                                   : running_minimum;
  assign duty_wide = {filt_ext[MIN_STATE_W-1], filt_ext} - {min_next[MIN_STATE_W-1], min_next};

  always_comb begin
    if (min_next[MIN_STATE_W-1:MIN_OUT_W-1] == '0 ||
        min_next[MIN_STATE_W-1:MIN_OUT_W-1] == '1) begin
      min_sat = min_next[MIN_OUT_W-1:0];
    end else if (min_next[MIN_STATE_W-1]) begin
      min_sat = MIN_OUT_LOW;
    end else begin
      min_sat = MIN_OUT_HIGH;
    end
  end

  // Duty is never negative: the minimum never exceeds the current value.
  assign duty_sat = (duty_wide[MIN_STATE_W:DUTY_W] != '0) ? DUTY_MAX
                                                         : duty_wide[DUTY_W-1:0];

  assign out_free     = !result_valid || result_ready;
  assign sample_ready = (state == S_IDLE);

  assign div_ctl.load = (state == S_DLOAD);
  assign div_ctl.step = (state == S_DIV);
  assign mul_ctl.load = (state == S_MLOAD);
  assign mul_ctl.step = (state == S_MUL);

  skts_divider #(
    .NUM_W (VAR_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_divider (
    .clk      (clk),
    .ctl      (div_ctl),
    .num      (variance),
    .den      (den),
    .quotient (gain)
  );

  skts_serial_mult #(
    .A_W (EST_W),
    .B_W (QUO_W)
  ) u_est_mult (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (innov_mag),
    .b       (gain),
    .product (est_prod)
  );

  skts_serial_mult #(
    .A_W (VAR_W),
    .B_W (QUO_W)
  ) u_var_mult (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (variance),
    .b       (gain),
    .product (var_prod)
  );

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RESET;
      measure_noise <= MEASURE_NOISE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROCESS_NOISE: process_noise <= wr_data;
        REG_MEASURE_NOISE: measure_noise <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      result_valid    <= 1'b0;
      estimate        <= ESTIMATE_RESET;
      variance        <= VARIANCE_RESET;
      running_minimum <= MINIMUM_RESET;
    end else begin
      // Drop the result once its beat is taken, unless the next one loads in its place.
      if (result_valid && result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            sample_r <= sample_temp;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          // Grow the variance and capture the innovation magnitude.
          variance  <= variance + {{(VAR_W-NOISE_W){1'b0}}, process_noise};
          innov_neg <= innov[INN_W-1];
          innov_mag <= innov_abs[EST_W-1:0];
          state     <= S_DLOAD;
        end
        S_DLOAD: begin
          cnt   <= CNT_W'(QUO_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_MLOAD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MLOAD: begin
          cnt   <= CNT_W'(QUO_W - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          if (cnt == '0) begin
            state <= S_UPD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_UPD: begin
          // Move the estimate toward the sample and shrink the variance.
          estimate <= innov_neg ? (estimate - est_prod[EST_W-1:0])
                                : (estimate + est_prod[EST_W-1:0]);
          variance <= variance - var_prod[VAR_W-1:0];
          state    <= S_FILT;
        end
        S_FILT: begin
          filtered <= estimate[EST_W-1] ? est_whole_neg[TEMP_W-1:0] : est_whole[TEMP_W-1:0];
          state    <= S_OUT;
        end
        S_OUT: begin
          // Hold here while an earlier result still waits.
          if (out_free) begin
            running_minimum <= min_next;
            filtered_temp   <= filtered;
            minimum_temp    <= min_sat;
            led_duty        <= duty_sat;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/skts_checker.sv]
// Port-level checker for the scalar Kalman temperature smoother, bound to the top level.
// Depends on skts_pkg for field widths.
module skts_checker import skts_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic signed [TEMP_W-1:0]    filtered_temp,
  input logic signed [MIN_OUT_W-1:0] minimum_temp,
  input logic [DUTY_W-1:0]           led_duty
);

  // A stalled result beat holds with its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(filtered_temp) &&
      $stable(minimum_temp) && $stable(led_duty))
    else $error("result beat changed while stalled");

  // Only one sample is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while another is in flight");

  // A sample cannot turn into a result in the next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && !result_valid |=> !result_valid)
    else $error("result appeared right after a sample");

  // The minimum never exceeds the value unless clipped low.
  a_min_below_value: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(filtered_temp) >= $signed(minimum_temp)) ||
      (minimum_temp == MIN_OUT_LOW))
    else $error("minimum above filtered value");

  // A value equal to an unclipped minimum gives a dark LED.
  a_zero_duty: assert property (@(posedge clk) disable iff (rst)
    result_valid && ($signed(filtered_temp) == $signed(minimum_temp)) &&
      (minimum_temp != MIN_OUT_LOW) |-> led_duty == '0)
    else $error("nonzero duty at the minimum");

endmodule

bind scalar_kalman_temperature_smoother skts_checker u_skts_checker (.*);
